[hw/rtl/hril_pkg.sv]
package hril_pkg;

    localparam int unsigned ADDR_W  = 17;
    localparam int unsigned TOP_W   = 18;
    localparam int unsigned DATA_W  = 48;
    localparam int unsigned RECIP_SHIFT = 30;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_HALT  = 2'd1;
    localparam logic [1:0] KIND_SIZE  = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_COLON  = 2'd1;
    localparam logic [1:0] ERR_MEMORY = 2'd2;

    typedef enum logic [2:0] {
        POS_FIRST = 3'd0,
        POS_COUNT = 3'd1,
        POS_ADDR  = 3'd2,
        POS_TYPE1 = 3'd3,
        POS_TYPE2 = 3'd4,
        POS_DATA  = 3'd5
    } t_pos;

    typedef struct packed {
        logic       eof;
        logic       newline;
        t_pos       pclass;
        logic       hold;
        logic       is_colon;
        logic       is_zero;
        logic [3:0] nibble;
    } t_item;

endpackage

[hw/rtl/hril_front.sv]
module hril_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_eof,
    input  logic [7:0]      i_char,
    input  logic            i_full,
    output logic            o_ready,
    output logic            o_push,
    output hril_pkg::t_item o_item
);

    localparam logic [9:0] POS_MAX = 10'd1023;

    logic [9:0] r_pos;
    logic [9:0] n_pos;
    logic       w_accept;
    logic       w_newline;
    logic       w_digit;

    assign o_ready   = !i_full;
    assign w_accept  = i_valid && !i_full;
    assign o_push    = w_accept;
    assign w_newline = (i_char == hril_pkg::CHAR_NEWLINE);
    assign w_digit   = (i_char >= 8'h30) && (i_char <= 8'h39);

    always_comb begin
        o_item          = '0;
        o_item.eof      = i_eof;
        o_item.newline  = w_newline;
        o_item.hold     = r_pos[0];
        o_item.is_colon = (i_char == hril_pkg::CHAR_COLON);
        o_item.is_zero  = (i_char == hril_pkg::CHAR_ZERO);
        // letters fold to 10..15, anything else wraps the same way
        o_item.nibble   = w_digit ? i_char[3:0] : (i_char[3:0] + 4'd9);
        if (r_pos == 10'd0) begin
            o_item.pclass = hril_pkg::POS_FIRST;
        end else if (r_pos <= 10'd2) begin
            o_item.pclass = hril_pkg::POS_COUNT;
        end else if (r_pos <= 10'd6) begin
            o_item.pclass = hril_pkg::POS_ADDR;
        end else if (r_pos == 10'd7) begin
            o_item.pclass = hril_pkg::POS_TYPE1;
        end else if (r_pos == 10'd8) begin
            o_item.pclass = hril_pkg::POS_TYPE2;
        end else begin
            o_item.pclass = hril_pkg::POS_DATA;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (i_eof || w_newline) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 10'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

[hw/rtl/hril_queue.sv]
module hril_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hril_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_avail,
    output hril_pkg::t_item o_item
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    hril_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [PTR_W:0]   n_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[hw/rtl/hril_back.sv]
module hril_back #(
    parameter int MEMORY_BYTES = 131072,
    parameter int PAGE_BYTES   = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_avail,
    input  hril_pkg::t_item             i_item,
    output logic                        o_pop,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic [1:0]                  o_m_tuser,
    output logic [hril_pkg::DATA_W-1:0] o_m_tdata
);

    localparam int unsigned AW  = hril_pkg::ADDR_W;
    localparam int unsigned TW  = hril_pkg::TOP_W;
    localparam int unsigned SH  = hril_pkg::RECIP_SHIFT;
    localparam logic [24:0] MEM_LIMIT = 25'(MEMORY_BYTES);
    localparam logic [AW-1:0] PAGE_M1 = AW'(PAGE_BYTES - 1);
    localparam logic [12:0] PAGE_N = 13'(PAGE_BYTES);
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam logic [SH-1:0] RECIP = SH'(RECIP_WIDE);
    localparam int unsigned PW = AW + SH;

    logic [7:0]    r_bytes,  n_bytes;
    logic [AW-1:0] r_addr,   n_addr;
    logic          r_rid,    n_rid;
    logic [3:0]    r_held,   n_held;
    logic [AW-1:0] r_hi,     n_hi;
    logic          r_halted, n_halted;
    logic [1:0]    r_settle, n_settle;
    logic [AW-1:0] r_q;
    logic [TW-1:0] r_top;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_kind,  n_out_kind;
    logic [AW-1:0] r_out_addr,  n_out_addr;
    logic [7:0]    r_out_byte,  n_out_byte;
    logic [1:0]    r_out_err,   n_out_err;
    logic [TW-1:0] r_out_top,   n_out_top;

    logic          w_room;
    logic          w_pop;
    logic [AW-1:0] w_end;
    logic [AW-1:0] w_x;
    logic [PW-1:0] w_prod;
    logic [29:0]   w_top_prod;

    assign w_room = !r_out_valid || i_m_tready;
    // end of file waits until the page rounding has caught up with the top
    assign w_pop  = i_avail && w_room && !(i_item.eof && (r_settle != 2'd0));
    assign o_pop  = w_pop;
    assign w_end  = {1'b0, r_addr[15:0]} + {9'd0, r_bytes};

    // ceil to page: floor((hi + p - 1) * recip >> shift) * p, exact for these widths
    assign w_x        = r_hi + PAGE_M1;
    assign w_prod     = PW'(w_x) * PW'(RECIP);
    assign w_top_prod = 30'(r_q) * 30'(PAGE_N);

    always_comb begin
        n_bytes     = r_bytes;
        n_addr      = r_addr;
        n_rid       = r_rid;
        n_held      = r_held;
        n_hi        = r_hi;
        n_halted    = r_halted;
        n_settle    = (r_settle == 2'd0) ? 2'd0 : (r_settle - 2'd1);
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_kind  = r_out_kind;
        n_out_addr  = r_out_addr;
        n_out_byte  = r_out_byte;
        n_out_err   = r_out_err;
        n_out_top   = r_out_top;
        if (w_pop && !r_halted) begin
            if (i_item.eof) begin
                n_out_valid = 1'b1;
                n_out_kind  = hril_pkg::KIND_SIZE;
                n_out_addr  = '0;
                n_out_byte  = '0;
                n_out_err   = hril_pkg::ERR_NONE;
                n_out_top   = r_top;
                n_bytes     = '0;
                n_addr      = '0;
                n_rid       = 1'b0;
                n_held      = '0;
                n_hi        = '0;
                n_settle    = 2'd2;
            end else if (i_item.newline) begin
                n_bytes = '0;
                n_addr  = '0;
                n_rid   = 1'b0;
                n_held  = '0;
            end else begin
                unique case (i_item.pclass)
                    hril_pkg::POS_FIRST: begin
                        if (!i_item.is_colon) begin
                            n_halted    = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_kind  = hril_pkg::KIND_HALT;
                            n_out_addr  = '0;
                            n_out_byte  = '0;
                            n_out_err   = hril_pkg::ERR_COLON;
                            n_out_top   = '0;
                        end else begin
                            n_bytes = '0;
                            n_addr  = '0;
                            n_rid   = 1'b0;
                        end
                    end
                    hril_pkg::POS_COUNT: begin
                        n_bytes = {r_bytes[3:0], i_item.nibble};
                    end
                    hril_pkg::POS_ADDR: begin
                        n_addr = {1'b0, r_addr[11:0], i_item.nibble};
                    end
                    hril_pkg::POS_TYPE1: begin
                        n_rid = i_item.is_zero;
                    end
                    hril_pkg::POS_TYPE2: begin
                        if (!(r_rid && i_item.is_zero)) begin
                            n_rid = 1'b0;
                        end else if ({8'd0, w_end} > MEM_LIMIT) begin
                            n_halted    = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_kind  = hril_pkg::KIND_HALT;
                            n_out_addr  = '0;
                            n_out_byte  = '0;
                            n_out_err   = hril_pkg::ERR_MEMORY;
                            n_out_top   = '0;
                        end else if (w_end > r_hi) begin
                            n_hi     = w_end;
                            n_settle = 2'd2;
                        end
                    end
                    hril_pkg::POS_DATA: begin
                        if (r_rid && (r_bytes != 8'd0)) begin
                            if (i_item.hold) begin
                                n_held = i_item.nibble;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_kind  = hril_pkg::KIND_WRITE;
                                n_out_addr  = r_addr;
                                n_out_byte  = {r_held, i_item.nibble};
                                n_out_err   = hril_pkg::ERR_NONE;
                                n_out_top   = '0;
                                n_addr      = r_addr + 1'b1;
                                n_bytes     = r_bytes - 8'd1;
                            end
                        end
                    end
                    default: begin
                        n_rid = r_rid;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q        <= w_prod[PW-1:SH];
        r_top      <= w_top_prod[TW-1:0];
        r_out_kind <= n_out_kind;
        r_out_addr <= n_out_addr;
        r_out_byte <= n_out_byte;
        r_out_err  <= n_out_err;
        r_out_top  <= n_out_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes     <= '0;
            r_addr      <= '0;
            r_rid       <= 1'b0;
            r_held      <= '0;
            r_hi        <= '0;
            r_halted    <= 1'b0;
            r_settle    <= 2'd2;
            r_out_valid <= 1'b0;
        end else begin
            r_bytes     <= n_bytes;
            r_addr      <= n_addr;
            r_rid       <= n_rid;
            r_held      <= n_held;
            r_hi        <= n_hi;
            r_halted    <= n_halted;
            r_settle    <= n_settle;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {3'd0, r_out_top, r_out_err, r_out_byte, r_out_addr};

endmodule

[hw/rtl/hex_record_image_loader_core.sv]
// Hex-record image loader: takes record text one character per request on the
// slave stream (tuser high marks end of file), emits one memory write per data
// byte of each type 00 record, an error result that halts the block until reset
// on a line not starting with ':' or a record running past MEMORY_BYTES, and at
// end of file the highest end address rounded up to a PAGE_BYTES page. A front
// stage classifies each character by its line position and decodes its nibble,
// a four-entry queue buffers classified characters, and a back stage holds the
// record state and a registered output. One character is taken per cycle while
// the queue has room; an end-of-file request waits after reset, after an earlier
// end of file or after a record that raised the top address, until the
// two-multiplier page rounding pipeline (r_q, then r_top) has caught up.
module hex_record_image_loader_core #(
    parameter int MEMORY_BYTES = 131072,
    parameter int PAGE_BYTES   = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,  // [7:0] char_code
    input  logic                        i_s_axis_tuser,  // [0] action
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [16:0] write_addr, [24:17] write_byte, [26:25] error_code,
    // [44:27] image_top, [47:45] zero
    output logic [hril_pkg::DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]                  o_m_axis_tuser   // [1:0] result_kind
);

    hril_pkg::t_item w_front_item;
    hril_pkg::t_item w_back_item;
    logic            w_push;
    logic            w_full;
    logic            w_avail;
    logic            w_pop;

    hril_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_eof   (i_s_axis_tuser),
        .i_char  (i_s_axis_tdata),
        .i_full  (w_full),
        .o_ready (o_s_axis_tready),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    hril_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_item  (w_back_item)
    );

    hril_back #(
        .MEMORY_BYTES (MEMORY_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (w_avail),
        .i_item     (w_back_item),
        .o_pop      (w_pop),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tuser  (o_m_axis_tuser),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

[verif/hex_record_image_loader_core_tb.sv]
`timescale 1ns / 100ps

module hex_record_image_loader_core_tb;

    localparam int MEM_SIZE   = 131072;
    localparam int PAGE_SIZE  = 128;
    localparam int POS_SAT    = 1023;
    localparam int FIRST_DATA = 9;
    localparam int QUIET_MAX  = 3000;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_ITEMS = 550;

    typedef struct {
        bit         pause;
        bit         eof;
        logic [7:0] ch;
        bit         steady;
    } t_char_req;

    typedef struct {
        logic [1:0]  kind;
        logic [16:0] addr;
        logic [7:0]  wdata;
        logic [1:0]  err;
        logic [17:0] top;
    } t_loader_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_valid = 1'b0;
    logic [7:0]                  s_char = '0;
    logic                        s_eof = 1'b0;
    logic                        m_ready = 1'b0;
    logic                        o_s_axis_tready;
    logic                        o_m_axis_tvalid;
    logic [hril_pkg::DATA_W-1:0] o_m_axis_tdata;
    logic [1:0]                  o_m_axis_tuser;

    t_char_req      char_reqs[$];
    t_loader_result results_due[$];
    bit             steady_mode = 1'b0;
    bit             burst = 1'b0;
    bit             drained = 1'b1;
    int             results_seen = 0;
    int             mismatches = 0;
    int             quiet = 0;
    int             hold_left = 0;
    bit             held_once = 1'b0;

    // predictor state
    logic [9:0]  ln_pos = '0;
    logic [7:0]  cnt_left = '0;
    logic [17:0] wr_addr = '0;
    logic        rec_is_data = 1'b0;
    logic [3:0]  hi_nib = '0;
    logic [17:0] max_end = '0;
    logic        stopped = 1'b0;

    hex_record_image_loader_core #(
        .MEMORY_BYTES(MEM_SIZE),
        .PAGE_BYTES  (PAGE_SIZE)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_char),
        .i_s_axis_tuser (s_eof),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [3:0] char_nibble(input logic [7:0] c);
        int v;
        v = c;
        if (v >= 48 && v <= 57)
            return 4'(v - 48);
        if (v >= 65 && v <= 90)
            v += 32;
        return 4'((v + 10 - 97) & 15);
    endfunction

    function automatic void clear_record();
        ln_pos      = '0;
        cnt_left    = '0;
        wr_addr     = '0;
        rec_is_data = 1'b0;
        hi_nib      = '0;
    endfunction

    // advances the loader state by one request, returns 1 when it yields a result
    function automatic bit decode_record_char(input bit eof, input logic [7:0] ch,
                                              output t_loader_result r);
        int         p;
        int         end_a;
        logic [3:0] n;
        r = '{default: '0};
        if (stopped)
            return 0;
        if (eof) begin
            r.kind = hril_pkg::KIND_SIZE;
            r.top  = 18'(((int'(max_end) + PAGE_SIZE - 1) / PAGE_SIZE) * PAGE_SIZE);
            clear_record();
            max_end = '0;
            return 1;
        end
        if (ch == hril_pkg::CHAR_NEWLINE) begin
            clear_record();
            return 0;
        end
        p = ln_pos;
        if (p < POS_SAT)
            ln_pos = 10'(p + 1);
        n = char_nibble(ch);
        if (p == 0) begin
            if (ch != hril_pkg::CHAR_COLON) begin
                stopped = 1'b1;
                r.kind  = hril_pkg::KIND_HALT;
                r.err   = hril_pkg::ERR_COLON;
                return 1;
            end
            cnt_left    = '0;
            wr_addr     = '0;
            rec_is_data = 1'b0;
            return 0;
        end
        if (p <= 2) begin
            cnt_left = {cnt_left[3:0], n};
            return 0;
        end
        if (p <= 6) begin
            wr_addr = {2'b00, wr_addr[11:0], n};
            return 0;
        end
        if (p == 7) begin
            rec_is_data = (ch == hril_pkg::CHAR_ZERO);
            return 0;
        end
        if (p == 8) begin
            if (!(rec_is_data && ch == hril_pkg::CHAR_ZERO)) begin
                rec_is_data = 1'b0;
                return 0;
            end
            end_a = int'(wr_addr) + int'(cnt_left);
            if (end_a > MEM_SIZE) begin
                stopped = 1'b1;
                r.kind  = hril_pkg::KIND_HALT;
                r.err   = hril_pkg::ERR_MEMORY;
                return 1;
            end
            if (end_a > int'(max_end))
                max_end = 18'(end_a);
            return 0;
        end
        if (!rec_is_data || cnt_left == 0)
            return 0;
        if (((p - FIRST_DATA) & 1) == 0) begin
            hi_nib = n;
            return 0;
        end
        r.kind   = hril_pkg::KIND_WRITE;
        r.addr   = wr_addr[16:0];
        r.wdata  = {hi_nib, n};
        wr_addr  = wr_addr + 18'd1;
        cnt_left = cnt_left - 8'd1;
        return 1;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10)
            return hril_pkg::CHAR_ZERO + v;
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] v;
        do
            v = 8'($urandom_range(255));
        while (v == hril_pkg::CHAR_NEWLINE);
        return v;
    endfunction

    task automatic push_char(input logic [7:0] ch);
        char_reqs.push_back('{pause: 1'b0, eof: 1'b0, ch: ch, steady: steady_mode});
    endtask

    task automatic push_eof();
        char_reqs.push_back('{pause: 1'b0, eof: 1'b1, ch: 8'($urandom_range(255)),
                              steady: steady_mode});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // one record line with random data; sometimes cut short before its newline
    task automatic push_record(input logic [7:0] cnt, input logic [15:0] addr,
                               input logic [7:0] th, input logic [7:0] tl, input int tail);
        logic [7:0] line[$];
        logic [7:0] b;
        int         cut;
        line.push_back(hril_pkg::CHAR_COLON);
        line.push_back(hex_char(cnt[7:4]));
        line.push_back(hex_char(cnt[3:0]));
        for (int i = 3; i >= 0; i--)
            line.push_back(hex_char(addr[i*4 +: 4]));
        line.push_back(th);
        line.push_back(tl);
        for (int i = 0; i < cnt; i++) begin
            b = 8'($urandom_range(255));
            line.push_back($urandom_range(19) == 0 ? noise_char() : hex_char(b[7:4]));
            line.push_back($urandom_range(19) == 0 ? noise_char() : hex_char(b[3:0]));
        end
        repeat (tail) line.push_back(noise_char());
        if ($urandom_range(6) == 0) begin
            cut = $urandom_range(1, line.size() - 1);
            while (line.size() > cut)
                void'(line.pop_back());
        end
        foreach (line[i])
            push_char(line[i]);
        push_char(hril_pkg::CHAR_NEWLINE);
    endtask

    // sender
    always @(posedge i_clk) begin : drive_proc
        t_char_req nxt;
        bit        offer;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || o_s_axis_tready) begin
            offer = 1'b0;
            if (char_reqs.size() > 0 && char_reqs[0].pause) begin
                // hold back until every expected result is out
                if (!s_valid && drained)
                    char_reqs.delete(0);
            end else if (char_reqs.size() > 0 &&
                         (char_reqs[0].steady || $urandom_range(99) >= 35)) begin
                nxt = char_reqs.pop_front();
                offer = 1'b1;
                s_eof <= nxt.eof;
                s_char <= nxt.ch;
                burst <= nxt.steady;
            end
            s_valid <= offer;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!held_once && results_seen >= 40) begin
            held_once <= 1'b1;
            hold_left <= HOLD_LEN;
            m_ready <= 1'b0;
        end else begin
            m_ready <= burst || ($urandom_range(99) >= 35);
        end
    end

    // prediction and checking
    always @(posedge i_clk) begin : monitor_proc
        t_loader_result want;
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                if (decode_record_char(s_eof, s_char, want))
                    results_due.push_back(want);
            end
            if (o_m_axis_tvalid && m_ready) begin
                results_seen <= results_seen + 1;
                if (results_due.size() == 0) begin
                    $error("result with none expected: kind %0d, data 'h%0h",
                           o_m_axis_tuser, o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", want.kind, o_m_axis_tuser);
                    check_field("write_addr", want.addr, o_m_axis_tdata[16:0]);
                    check_field("write_byte", want.wdata, o_m_axis_tdata[24:17]);
                    check_field("error_code", want.err, o_m_axis_tdata[26:25]);
                    check_field("image_top", want.top, o_m_axis_tdata[44:27]);
                end
            end
            drained <= (results_due.size() == 0);
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("** hex_record_image_loader_core: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stim_proc
        int         base;
        int         files;
        int         sel;
        int         pick;
        logic [7:0] cnt;
        logic [15:0] addr;
        logic [7:0] th;
        logic [7:0] tl;
        logic [7:0] bad;

        // directed: empty file, empty line, top-address write, short lines
        push_eof();
        push_char(hril_pkg::CHAR_NEWLINE);
        push_text(":01FFFF00aF\n");
        push_text(":02000000x\n");
        push_text(":0\n");
        push_eof();

        base = char_reqs.size();
        files = 0;
        while (char_reqs.size() - base < RAND_ITEMS || files < 3) begin
            steady_mode = (files == 2);
            repeat ($urandom_range(1, 6)) begin
                sel = $urandom_range(99);
                if (sel < 8) begin
                    push_char(hril_pkg::CHAR_NEWLINE);
                end else if (sel < 16) begin
                    push_char(hril_pkg::CHAR_COLON);
                    repeat ($urandom_range(0, 20)) push_char(noise_char());
                    push_char(hril_pkg::CHAR_NEWLINE);
                end else begin
                    pick = $urandom_range(99);
                    cnt = (pick < 3) ? 8'd255 :
                          (pick < 70) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(9, 40));
                    pick = $urandom_range(99);
                    addr = (pick < 20) ? 16'h0000 :
                           (pick < 40) ? 16'($urandom_range(16'hFF00, 16'hFFFF)) :
                           16'($urandom_range(16'hFFFF));
                    if ($urandom_range(4) != 0) begin
                        th = hril_pkg::CHAR_ZERO;
                        tl = hril_pkg::CHAR_ZERO;
                    end else begin
                        th = $urandom_range(3) == 0 ? noise_char() :
                             hex_char(4'($urandom_range(15)));
                        tl = $urandom_range(3) == 0 ? noise_char() :
                             hex_char(4'($urandom_range(15)));
                    end
                    push_record(cnt, addr, th, tl,
                                $urandom_range(3) == 0 ? $urandom_range(1, 6) : 0);
                end
            end
            if ($urandom_range(6) == 0) begin
                push_char(hril_pkg::CHAR_COLON);
                repeat ($urandom_range(0, 12)) push_char(hex_char(4'($urandom_range(15))));
            end
            push_eof();
            if (files % 3 == 2)
                char_reqs.push_back('{pause: 1'b1, eof: 1'b0, ch: '0, steady: 1'b0});
            files++;
        end
        steady_mode = 1'b0;

        // a bad first character halts the block; everything after is dropped
        push_record(8'($urandom_range(1, 8)), 16'($urandom_range(16'hFFFF)),
                    hril_pkg::CHAR_ZERO, hril_pkg::CHAR_ZERO, 0);
        pick = $urandom_range(2);
        if (pick == 0)
            bad = 8'h00;
        else if (pick == 1)
            bad = 8'hFF;
        else begin
            do
                bad = noise_char();
            while (bad == hril_pkg::CHAR_COLON);
        end
        push_char(bad);
        repeat (6) push_char(noise_char());
        push_char(hril_pkg::CHAR_NEWLINE);
        push_text(":0100000011\n");
        push_eof();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (char_reqs.size() != 0 || s_valid || !drained)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** hex_record_image_loader_core: PASSED **");
        else
            $display("** hex_record_image_loader_core: FAILED **");
        $finish;
    end

endmodule

[hex_record_image_loader_core.f]
hw/rtl/hril_pkg.sv
hw/rtl/hril_front.sv
hw/rtl/hril_queue.sv
hw/rtl/hril_back.sv
hw/rtl/hex_record_image_loader_core.sv
verif/hex_record_image_loader_core_tb.sv
